@@ src/bpdc_pkg.sv @@
`timescale 1ns / 1ps
// Shared types and constants for the beam pair direction counter.
// No dependencies; imported by beam_pair_direction_counter.
package bpdc_pkg;

    localparam int COUNTER_BITS = 16;
    localparam int FIELD_W      = 16;
    localparam int TIME_W       = 16;

    localparam logic [TIME_W-1:0] TIME_LIMIT_RESET = TIME_W'(60);

    typedef logic [COUNTER_BITS-1:0] cnt_t;
    typedef logic [FIELD_W-1:0]      field_t;
    typedef logic [TIME_W-1:0]       secs_t;

    typedef enum logic [3:0] {
        PH_START = 4'd0,
        PH_IDLE  = 4'd1,
        PH_IN1   = 4'd2,
        PH_IN2   = 4'd3,
        PH_IN3   = 4'd4,
        PH_OUT1  = 4'd5,
        PH_OUT2  = 4'd6,
        PH_OUT3  = 4'd7,
        PH_DONE  = 4'd8
    } phase_t;

    // Saturating increment of a break or crossing counter.
    function automatic cnt_t sat_inc(cnt_t c);
        cnt_t r;
        r = c;
        if (c != {COUNTER_BITS{1'b1}})
        begin
            r = c + cnt_t'(1);
        end
        return r;
    endfunction

    // Low bits of a counter, zero extended when the counter is narrower.
    function automatic field_t to_field(cnt_t c);
        logic [COUNTER_BITS+FIELD_W-1:0] wide;
        wide = {{FIELD_W{1'b0}}, c};
        return wide[FIELD_W-1:0];
    endfunction

endpackage

@@ src/beam_pair_direction_counter.sv @@
`timescale 1ns / 1ps
// Two-beam bidirectional people counter: crossing state machine, saturating
// counters and a registered result stage. Depends on bpdc_pkg.
//
//  Channel | Handshake              | Payload
//  --------+------------------------+------------------------------------------
//  in      | in_valid / in_ready    | left_beam_intact, right_beam_intact,
//          |                        | elapsed_seconds
//  out     | out_valid / out_ready  | left_breaks, right_breaks, entered,
//          |                        | exited, finished
//  cfg     | cfg_valid / cfg_ready  | cfg_data (time_limit)
//
// Each sample beat is taken on an in_valid/in_ready handshake; its result
// appears in the output register on the next cycle, so a new beat can be
// taken every cycle while out_ready is high. The output register is the
// only stage; in_ready is low only while a result waits and out_ready is low.
// Reset puts the machine in its start state, clears all counters and loads
// the time limit with 60 seconds. cfg_ready is always high.
module beam_pair_direction_counter (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  logic                  left_beam_intact,
    input  logic                  right_beam_intact,
    input  bpdc_pkg::secs_t       elapsed_seconds,
    output logic                  out_valid,
    input  logic                  out_ready,
    output bpdc_pkg::field_t      left_breaks,
    output bpdc_pkg::field_t      right_breaks,
    output bpdc_pkg::field_t      entered,
    output bpdc_pkg::field_t      exited,
    output logic                  finished,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  bpdc_pkg::secs_t       cfg_data
);
    import bpdc_pkg::*;

    phase_t phase_reg, phase_next;
    cnt_t   left_cnt_reg, left_cnt_next;
    cnt_t   right_cnt_reg, right_cnt_next;
    cnt_t   entry_cnt_reg, entry_cnt_next;
    cnt_t   exit_cnt_reg, exit_cnt_next;
    secs_t  limit_reg;
    logic   out_valid_reg;
    field_t left_out_reg, right_out_reg, entry_out_reg, exit_out_reg;
    logic   finished_reg;
    logic   in_fire;
    logic   left_ok, right_ok;

    assign in_ready  = !out_valid_reg || out_ready;
    assign in_fire   = in_valid && in_ready;
    assign cfg_ready = 1'b1;
    assign left_ok   = left_beam_intact;
    assign right_ok  = right_beam_intact;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            limit_reg <= TIME_LIMIT_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            limit_reg <= cfg_data;
        end
    end

    always_comb
    begin
        phase_next     = phase_reg;
        left_cnt_next  = left_cnt_reg;
        right_cnt_next = right_cnt_reg;
        entry_cnt_next = entry_cnt_reg;
        exit_cnt_next  = exit_cnt_reg;
        if (in_fire && phase_reg != PH_DONE)
        begin
            if (elapsed_seconds >= limit_reg)
            begin
                phase_next = PH_DONE;
            end
            else
            begin
                unique case (phase_reg)
                    PH_IDLE:
                    begin
                        if (!left_ok)
                        begin
                            phase_next    = PH_IN1;
                            left_cnt_next = sat_inc(left_cnt_reg);
                        end
                        else if (!right_ok)
                        begin
                            phase_next     = PH_OUT1;
                            right_cnt_next = sat_inc(right_cnt_reg);
                        end
                    end
                    PH_IN1:
                    begin
                        if (!right_ok)
                        begin
                            phase_next     = PH_IN2;
                            right_cnt_next = sat_inc(right_cnt_reg);
                        end
                        else if (left_ok)
                        begin
                            phase_next = PH_IDLE;
                        end
                    end
                    PH_IN2:
                    begin
                        if (left_ok)
                        begin
                            phase_next = PH_IN3;
                        end
                        else if (right_ok)
                        begin
                            phase_next = PH_IN1;
                        end
                    end
                    PH_IN3:
                    begin
                        if (right_ok)
                        begin
                            phase_next     = PH_IDLE;
                            entry_cnt_next = sat_inc(entry_cnt_reg);
                        end
                        else if (!left_ok)
                        begin
                            phase_next    = PH_IN2;
                            left_cnt_next = sat_inc(left_cnt_reg);
                        end
                    end
                    PH_OUT1:
                    begin
                        if (!left_ok)
                        begin
                            phase_next    = PH_OUT2;
                            left_cnt_next = sat_inc(left_cnt_reg);
                        end
                        else if (right_ok)
                        begin
                            phase_next = PH_IDLE;
                        end
                    end
                    PH_OUT2:
                    begin
                        if (right_ok)
                        begin
                            phase_next = PH_OUT3;
                        end
                        else if (left_ok)
                        begin
                            phase_next = PH_OUT1;
                        end
                    end
                    PH_OUT3:
                    begin
                        if (left_ok)
                        begin
                            phase_next    = PH_IDLE;
                            exit_cnt_next = sat_inc(exit_cnt_reg);
                        end
                        else if (!right_ok)
                        begin
                            phase_next     = PH_OUT2;
                            right_cnt_next = sat_inc(right_cnt_reg);
                        end
                    end
                    default:
                    begin
                        phase_next = PH_IDLE;
                    end
                endcase
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_START;
            left_cnt_reg  <= '0;
            right_cnt_reg <= '0;
            entry_cnt_reg <= '0;
            exit_cnt_reg  <= '0;
        end
        else
        begin
            phase_reg     <= phase_next;
            left_cnt_reg  <= left_cnt_next;
            right_cnt_reg <= right_cnt_next;
            entry_cnt_reg <= entry_cnt_next;
            exit_cnt_reg  <= exit_cnt_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            out_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            left_out_reg  <= to_field(left_cnt_next);
            right_out_reg <= to_field(right_cnt_next);
            entry_out_reg <= to_field(entry_cnt_next);
            exit_out_reg  <= to_field(exit_cnt_next);
            finished_reg  <= (phase_next == PH_DONE);
        end
    end

    assign out_valid    = out_valid_reg;
    assign left_breaks  = left_out_reg;
    assign right_breaks = right_out_reg;
    assign entered      = entry_out_reg;
    assign exited       = exit_out_reg;
    assign finished     = finished_reg;

`ifndef SYNTHESIS
    // The done state is sticky until reset.
    a_done_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        phase_reg == PH_DONE |=> phase_reg == PH_DONE)
        else $error("done state was left");

    // Counters are frozen once done.
    a_done_frozen: assert property (@(posedge clk) disable iff (!rst_n)
        phase_reg == PH_DONE |=> $stable(left_cnt_reg) && $stable(right_cnt_reg)
            && $stable(entry_cnt_reg) && $stable(exit_cnt_reg))
        else $error("counter moved in done state");

    // A sample at or past the limit ends counting.
    a_limit_stops: assert property (@(posedge clk) disable iff (!rst_n)
        in_fire && elapsed_seconds >= limit_reg |=> phase_reg == PH_DONE)
        else $error("time limit did not stop counting");

    // An entry is only counted when leaving the last inbound phase.
    a_entry_source: assert property (@(posedge clk) disable iff (!rst_n)
        in_fire && entry_cnt_next != entry_cnt_reg |-> phase_reg == PH_IN3)
        else $error("entry counted from wrong phase");

    // An accepted beat always leaves a result waiting.
    a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
        in_fire |=> out_valid_reg)
        else $error("accepted beat produced no result");
`endif

endmodule

@@ test/beam_pair_direction_counter_test.sv @@
`timescale 1ns / 1ps
// Self-checking bench for beam_pair_direction_counter: sensor beats in, count beats out.
// Depends on bpdc_pkg and beam_pair_direction_counter; checks come from its own tally model.
module beam_pair_direction_counter_test;

    import bpdc_pkg::*;

    localparam int QUIET_LIMIT = 2000;
    localparam int IDLE_PCT    = 38;

    // Beam codes are {left_intact, right_intact}.
    localparam logic [1:0] CLEAR     = 2'b11;
    localparam logic [1:0] LEFT_CUT  = 2'b01;
    localparam logic [1:0] RIGHT_CUT = 2'b10;
    localparam logic [1:0] BOTH_CUT  = 2'b00;

    typedef struct {
        field_t left_n;
        field_t right_n;
        field_t entries;
        field_t exits;
        logic   done;
    } tally_t;

    class crossing_ledger;
        phase_t crossing;
        cnt_t   left_cnt;
        cnt_t   right_cnt;
        cnt_t   entry_cnt;
        cnt_t   exit_cnt;
        secs_t  limit;
        tally_t tallies_due[$];
        int     errors;
        int     checked;

        function new();
            crossing  = PH_START;
            left_cnt  = '0;
            right_cnt = '0;
            entry_cnt = '0;
            exit_cnt  = '0;
            limit     = TIME_LIMIT_RESET;
            errors    = 0;
            checked   = 0;
        endfunction

        function void set_limit(secs_t v);
            limit = v;
        endfunction

        function int pending();
            return tallies_due.size();
        endfunction

        function cnt_t bumped(cnt_t c);
            return (&c) ? c : c + cnt_t'(1);
        endfunction

        function void note_sample(logic left_ok, logic right_ok, secs_t secs);
            tally_t t;
            if (crossing != PH_DONE)
            begin
                if (secs >= limit)
                begin
                    crossing = PH_DONE;
                end
                else
                begin
                    case (crossing)
                        PH_IDLE:
                        begin
                            if (!left_ok)
                            begin
                                crossing = PH_IN1;
                                left_cnt = bumped(left_cnt);
                            end
                            else if (!right_ok)
                            begin
                                crossing  = PH_OUT1;
                                right_cnt = bumped(right_cnt);
                            end
                        end
                        PH_IN1:
                        begin
                            if (!right_ok)
                            begin
                                crossing  = PH_IN2;
                                right_cnt = bumped(right_cnt);
                            end
                            else if (left_ok)
                            begin
                                crossing = PH_IDLE;
                            end
                        end
                        PH_IN2:
                        begin
                            if (left_ok)
                            begin
                                crossing = PH_IN3;
                            end
                            else if (right_ok)
                            begin
                                crossing = PH_IN1;
                            end
                        end
                        PH_IN3:
                        begin
                            if (right_ok)
                            begin
                                crossing  = PH_IDLE;
                                entry_cnt = bumped(entry_cnt);
                            end
                            else if (!left_ok)
                            begin
                                crossing = PH_IN2;
                                left_cnt = bumped(left_cnt);
                            end
                        end
                        PH_OUT1:
                        begin
                            if (!left_ok)
                            begin
                                crossing = PH_OUT2;
                                left_cnt = bumped(left_cnt);
                            end
                            else if (right_ok)
                            begin
                                crossing = PH_IDLE;
                            end
                        end
                        PH_OUT2:
                        begin
                            if (right_ok)
                            begin
                                crossing = PH_OUT3;
                            end
                            else if (left_ok)
                            begin
                                crossing = PH_OUT1;
                            end
                        end
                        PH_OUT3:
                        begin
                            if (left_ok)
                            begin
                                crossing = PH_IDLE;
                                exit_cnt = bumped(exit_cnt);
                            end
                            else if (!right_ok)
                            begin
                                crossing  = PH_OUT2;
                                right_cnt = bumped(right_cnt);
                            end
                        end
                        default:
                        begin
                            crossing = PH_IDLE;
                        end
                    endcase
                end
            end
            t.left_n  = field_t'(left_cnt);
            t.right_n = field_t'(right_cnt);
            t.entries = field_t'(entry_cnt);
            t.exits   = field_t'(exit_cnt);
            t.done    = (crossing == PH_DONE);
            tallies_due.push_back(t);
        endfunction

        task report(string what);
            if (errors < 100)
            begin
                $display("%0t: %s", $time, what);
            end
            errors++;
        endtask

        task check_tally(tally_t got);
            tally_t want;
            if (tallies_due.size() == 0)
            begin
                report("result beat arrived with nothing expected");
            end
            else
            begin
                want = tallies_due.pop_front();
                checked++;
                if (got.left_n !== want.left_n)
                begin
                    report($sformatf("left_breaks %0d, expected %0d", got.left_n, want.left_n));
                end
                if (got.right_n !== want.right_n)
                begin
                    report($sformatf("right_breaks %0d, expected %0d",
                                     got.right_n, want.right_n));
                end
                if (got.entries !== want.entries)
                begin
                    report($sformatf("entered %0d, expected %0d", got.entries, want.entries));
                end
                if (got.exits !== want.exits)
                begin
                    report($sformatf("exited %0d, expected %0d", got.exits, want.exits));
                end
                if (got.done !== want.done)
                begin
                    report($sformatf("finished %0b, expected %0b", got.done, want.done));
                end
            end
        endtask
    endclass

    logic    clk;
    logic    rst_n;
    logic    in_valid;
    logic    in_ready;
    logic    left_beam_intact;
    logic    right_beam_intact;
    secs_t   elapsed_seconds;
    logic    out_valid;
    logic    out_ready;
    field_t  left_breaks;
    field_t  right_breaks;
    field_t  entered;
    field_t  exited;
    logic    finished;
    logic    cfg_valid;
    logic    cfg_ready;
    secs_t   cfg_data;

    crossing_ledger ledger = new();
    tally_t seen;
    int     tx_idle_pct = IDLE_PCT;
    int     rx_idle_pct = IDLE_PCT;
    int     limit_now = 60;
    int     mid_limit;
    int     beats_sent = 0;
    int     quiet_cycles = 0;

    beam_pair_direction_counter DUT (
        .clk               (clk),
        .rst_n             (rst_n),
        .in_valid          (in_valid),
        .in_ready          (in_ready),
        .left_beam_intact  (left_beam_intact),
        .right_beam_intact (right_beam_intact),
        .elapsed_seconds   (elapsed_seconds),
        .out_valid         (out_valid),
        .out_ready         (out_ready),
        .left_breaks       (left_breaks),
        .right_breaks      (right_breaks),
        .entered           (entered),
        .exited            (exited),
        .finished          (finished),
        .cfg_valid         (cfg_valid),
        .cfg_ready         (cfg_ready),
        .cfg_data          (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
    end

    always #2 clk = ~clk;

    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
        begin
            seen.left_n  = left_breaks;
            seen.right_n = right_breaks;
            seen.entries = entered;
            seen.exits   = exited;
            seen.done    = finished;
            ledger.check_tally(seen);
        end
        out_ready <= ($urandom_range(0, 99) >= rx_idle_pct);
    end

    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
        begin
            quiet_cycles <= 0;
        end
        else if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("Timed out after %0d cycles without a beat.", QUIET_LIMIT);
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
        else
        begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    function automatic secs_t pick_secs();
        int r;
        r = $urandom_range(0, 9);
        if (r == 0)
        begin
            return '0;
        end
        else if (r == 1)
        begin
            return secs_t'(limit_now - 1);
        end
        return secs_t'($urandom_range(0, limit_now - 1));
    endfunction

    task send_beams(input logic [1:0] beams, input secs_t secs);
        while ($urandom_range(0, 99) < tx_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid          <= 1'b1;
        left_beam_intact  <= beams[1];
        right_beam_intact <= beams[0];
        elapsed_seconds   <= secs;
        @(posedge clk);
        while (!in_ready)
        begin
            @(posedge clk);
        end
        ledger.note_sample(beams[1], beams[0], secs);
        beats_sent++;
    endtask

    task drain_results();
        in_valid <= 1'b0;
        while (ledger.pending() != 0)
        begin
            @(posedge clk);
        end
    endtask

    task set_time_limit(input int v);
        drain_results();
        cfg_valid <= 1'b1;
        cfg_data  <= secs_t'(v);
        @(posedge clk);
        while (!cfg_ready)
        begin
            @(posedge clk);
        end
        cfg_valid <= 1'b0;
        ledger.set_limit(secs_t'(v));
        limit_now = v;
    endtask

    task step(input logic [1:0] code, input bit mirror);
        logic [1:0] beams;
        int holds;
        beams = mirror ? {code[0], code[1]} : code;
        holds = ($urandom_range(0, 5) == 0) ? 2 : 1;
        repeat (holds) send_beams(beams, pick_secs());
    endtask

    // A crossing in either direction, sometimes abandoned, sometimes backing up.
    task walk_crossing(input bit mirror);
        int loops;
        int k;
        step(LEFT_CUT, mirror);
        if ($urandom_range(0, 7) == 0)
        begin
            step(CLEAR, mirror);
        end
        else
        begin
            step(BOTH_CUT, mirror);
            loops = ($urandom_range(0, 2) == 0) ? $urandom_range(1, 3) : 0;
            for (k = 0; k < loops; k++)
            begin
                step($urandom_range(0, 1) ? RIGHT_CUT : LEFT_CUT, mirror);
                step(BOTH_CUT, mirror);
            end
            step(RIGHT_CUT, mirror);
            step(CLEAR, mirror);
        end
    endtask

    task run_samples(input int count);
        int target;
        int n;
        target = beats_sent + count;
        while (beats_sent < target)
        begin
            if ($urandom_range(0, 9) < 7)
            begin
                walk_crossing($urandom_range(0, 1));
            end
            else
            begin
                n = $urandom_range(1, 4);
                repeat (n) send_beams(2'($urandom_range(0, 3)), pick_secs());
            end
        end
    endtask

    initial
    begin
        rst_n             = 1'b0;
        in_valid          <= 1'b0;
        left_beam_intact  <= 1'b1;
        right_beam_intact <= 1'b1;
        elapsed_seconds   <= '0;
        out_ready         <= 1'b0;
        cfg_valid         <= 1'b0;
        cfg_data          <= '0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;

        // The first beat only leaves the start state, so its broken beams count nothing.
        send_beams(BOTH_CUT, 16'd59);
        send_beams(LEFT_CUT, 16'd0);
        send_beams(BOTH_CUT, 16'd1);
        send_beams(RIGHT_CUT, 16'd2);
        send_beams(CLEAR, 16'd59);

        set_time_limit(65535);
        send_beams(RIGHT_CUT, 16'd65534);
        send_beams(BOTH_CUT, pick_secs());
        send_beams(LEFT_CUT, pick_secs());
        send_beams(BOTH_CUT, pick_secs());
        send_beams(RIGHT_CUT, pick_secs());
        send_beams(BOTH_CUT, pick_secs());
        send_beams(LEFT_CUT, pick_secs());
        send_beams(CLEAR, pick_secs());
        send_beams(LEFT_CUT, pick_secs());
        send_beams(CLEAR, pick_secs());
        send_beams(LEFT_CUT, pick_secs());
        send_beams(BOTH_CUT, pick_secs());
        send_beams(LEFT_CUT, pick_secs());
        send_beams(BOTH_CUT, pick_secs());
        send_beams(RIGHT_CUT, pick_secs());
        send_beams(BOTH_CUT, pick_secs());
        send_beams(RIGHT_CUT, pick_secs());
        send_beams(CLEAR, pick_secs());
        send_beams(RIGHT_CUT, pick_secs());
        send_beams(CLEAR, pick_secs());

        run_samples(120);
        drain_results();
        run_samples(130);

        mid_limit = $urandom_range(2, 65534);
        set_time_limit(mid_limit);
        run_samples(150);

        set_time_limit(1);
        run_samples(60);

        // Crossings in both directions at full rate, with no idling on either side.
        set_time_limit(65535);
        tx_idle_pct = 0;
        rx_idle_pct = 0;
        repeat (6)
        begin
            send_beams(LEFT_CUT, pick_secs());
            send_beams(BOTH_CUT, pick_secs());
            send_beams(RIGHT_CUT, pick_secs());
            send_beams(CLEAR, pick_secs());
            send_beams(RIGHT_CUT, pick_secs());
            send_beams(BOTH_CUT, pick_secs());
            send_beams(LEFT_CUT, pick_secs());
            send_beams(CLEAR, pick_secs());
        end
        tx_idle_pct = IDLE_PCT;
        rx_idle_pct = IDLE_PCT;
        run_samples(100);

        // A zero limit stops counting on the next beat, and the counts stay frozen.
        set_time_limit(0);
        send_beams(LEFT_CUT, 16'd0);
        send_beams(CLEAR, 16'hFFFF);
        repeat (38) send_beams(2'($urandom_range(0, 3)), secs_t'($urandom_range(0, 65535)));

        drain_results();
        repeat (8) @(posedge clk);
        if (ledger.pending() != 0)
        begin
            ledger.report($sformatf("%0d expected result beats never arrived", ledger.pending()));
        end
        $display("Sent %0d sample beats and checked %0d result beats across time limits",
                 beats_sent, ledger.checked);
        $display("of 60, 65535, %0d, 1 and 0 seconds, including a stretch at full rate.",
                 mid_limit);
        if (ledger.errors == 0)
        begin
            $display("SCOREBOARD CLEAN");
        end
        else
        begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule
